// ===== rtl/plk_pkg.sv =====
// ----------------------------------------------------------------------------
// plk_pkg: shared types and constants for the link provisioning controller
// Holds the state encoding, the event opcodes, register indexes and the
// word types passed between the input stage and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package plk_pkg;

    // field widths
    localparam int OP_W     = 4;
    localparam int TIME_W   = 48;
    localparam int LIMIT_W  = 32;
    localparam int CNT_W    = 8;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W = 1;

    // register reset values
    localparam logic [CNT_W-1:0]   RAISE_THRESHOLD_RST = 8'd3;
    localparam logic [LIMIT_W-1:0] GRACE_LIMIT_RST     = 32'd300000;
    localparam logic [CNT_W-1:0]   CNT_MAX             = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_LIMIT     = 1'b1;

    // reported state codes
    localparam logic [CODE_W-1:0] CODE_UNPROV  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_CONNECT = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ASSIST  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_GRACE   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_STAONLY = 3'd4;

    // one-hot controller state
    typedef enum logic [4:0] {
        S_UNPROV  = 5'b00001,
        S_CONNECT = 5'b00010,
        S_ASSIST  = 5'b00100,
        S_GRACE   = 5'b01000,
        S_STAONLY = 5'b10000
    } t_state;

    // event opcodes
    typedef enum logic [OP_W-1:0] {
        OP_INIT        = 4'd0,
        OP_CONNECTED   = 4'd1,
        OP_FAILED      = 4'd2,
        OP_LOST        = 4'd3,
        OP_SUBMITTED   = 4'd4,
        OP_CLEARED     = 4'd5,
        OP_CLIENT_LEFT = 4'd6,
        OP_TICK        = 4'd7,
        OP_RAISE       = 4'd8,
        OP_TEARDOWN    = 4'd9
    } t_opcode;

    // one input word
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] now_ms;
        logic              boot_has_credentials;
    } t_item;

    // one result word
    typedef struct packed {
        logic [CODE_W-1:0] state_code;
        logic              ap_up;
        logic              raise_advised;
        logic              teardown_advised;
        logic              credentials_proven;
        logic [CNT_W-1:0]  retry_count;
        logic [CNT_W-1:0]  trigger_count;
    } t_result;

    // configuration write
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [LIMIT_W-1:0]   data;
    } t_cfg_wr;

    // map the one-hot state to its reported code
    function automatic logic [CODE_W-1:0] state_code(input t_state s);
        logic [CODE_W-1:0] c;
        unique case (s)
            S_UNPROV:  c = CODE_UNPROV;
            S_CONNECT: c = CODE_CONNECT;
            S_ASSIST:  c = CODE_ASSIST;
            S_GRACE:   c = CODE_GRACE;
            S_STAONLY: c = CODE_STAONLY;
            default:   c = CODE_UNPROV;
        endcase
        return c;
    endfunction

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/provisioning_link_fsm.sv =====
// An accepted event word is held in the input register and its state update
// lands in the result register. Throughput: one event word per cycle unless
// the result channel stalls; the state update itself is combinational.
// Reset (synchronous, active low) returns the state to unprovisioned, clears
// flags, counters and grace start, and restores the two registers' defaults.
// ----------------------------------------------------------------------------
// provisioning_link_fsm: link provisioning controller, top level
// Five-state controller advising when to raise and tear down the access point.
// ----------------------------------------------------------------------------
`default_nettype none

module provisioning_link_fsm (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // event channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [plk_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [plk_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic                           i_boot_has_credentials,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [plk_pkg::CODE_W-1:0]          o_state_code,
    output logic                                o_ap_up,
    output logic                                o_raise_advised,
    output logic                                o_teardown_advised,
    output logic                                o_credentials_proven,
    output logic [plk_pkg::CNT_W-1:0]           o_retry_count,
    output logic [plk_pkg::CNT_W-1:0]           o_trigger_count,
    // configuration write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [plk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [plk_pkg::LIMIT_W-1:0]    i_cfg_data
);
    import plk_pkg::*;

    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_vld;
    logic    w_advance;
    t_cfg_wr w_cfg;
    t_result w_result;

    // gather the event word
    assign w_in_item.opcode               = i_opcode;
    assign w_in_item.now_ms               = i_now_ms;
    assign w_in_item.boot_has_credentials = i_boot_has_credentials;

    // configuration is always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    plk_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (w_in_item),
        .i_advance  (w_advance),
        .o_item_vld (w_s1_vld),
        .o_item     (w_s1_item)
    );

    plk_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_item_vld (w_s1_vld),
        .i_item     (w_s1_item),
        .o_advance  (w_advance),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (w_result)
    );

    // unpack the result word
    assign o_state_code         = w_result.state_code;
    assign o_ap_up              = w_result.ap_up;
    assign o_raise_advised      = w_result.raise_advised;
    assign o_teardown_advised   = w_result.teardown_advised;
    assign o_credentials_proven = w_result.credentials_proven;
    assign o_retry_count        = w_result.retry_count;
    assign o_trigger_count      = w_result.trigger_count;

endmodule

`default_nettype wire

// ===== rtl/plk_in_reg.sv =====
// ----------------------------------------------------------------------------
// plk_in_reg: input register stage
// Captures one event word and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module plk_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire plk_pkg::t_item i_item,
    input  wire logic          i_advance,
    output logic               o_item_vld,
    output plk_pkg::t_item     o_item
);
    import plk_pkg::*;

    logic  r_vld;
    t_item r_item;
    logic  w_load;

    // stage is free when empty or moving on this cycle
    assign o_stall = r_vld && !i_advance;
    assign w_load  = i_valid && !o_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_item_vld = r_vld;
    assign o_item     = r_item;

endmodule

`default_nettype wire

// ===== rtl/plk_core.sv =====
// ----------------------------------------------------------------------------
// plk_core: controller state, configuration and result register
// Applies one event to the state combinationally and registers the report.
// ----------------------------------------------------------------------------
`default_nettype none

module plk_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire plk_pkg::t_cfg_wr i_cfg,
    input  wire logic            i_item_vld,
    input  wire plk_pkg::t_item  i_item,
    output logic                 o_advance,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output plk_pkg::t_result     o_result
);
    import plk_pkg::*;

    // configuration
    logic [CNT_W-1:0]   r_thresh;
    logic [LIMIT_W-1:0] r_limit;

    // controller state
    t_state             r_state,   n_state;
    logic               r_creds,   n_creds;
    logic [CNT_W-1:0]   r_retries, n_retries;
    logic [CNT_W-1:0]   r_trig,    n_trig;
    logic               r_ap,      n_ap;
    logic [TIME_W-1:0]  r_gstart,  n_gstart;

    // result register
    logic    r_out_vld;
    t_result r_out;
    t_result n_out;

    logic [TIME_W:0]   w_diff;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_step;

    // output register free or being drained
    assign o_advance = !r_out_vld || !i_stall;
    assign w_step    = o_advance && i_item_vld;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= RAISE_THRESHOLD_RST;
            r_limit  <= GRACE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RAISE_THRESHOLD: r_thresh <= i_cfg.data[CNT_W-1:0];
                CFG_GRACE_LIMIT:     r_limit  <= i_cfg.data;
                default:             r_limit  <= r_limit;
            endcase
        end
    end

    // event decode and next state
    always_comb begin
        n_state   = r_state;
        n_creds   = r_creds;
        n_retries = r_retries;
        n_trig    = r_trig;
        n_ap      = r_ap;
        n_gstart  = r_gstart;
        unique case (t_opcode'(i_item.opcode))
            OP_INIT: begin
                n_creds   = i_item.boot_has_credentials;
                n_retries = '0;
                n_trig    = '0;
                n_gstart  = '0;
                if (i_item.boot_has_credentials) begin
                    n_state = S_CONNECT;
                    n_ap    = 1'b0;
                end else begin
                    n_state = S_UNPROV;
                    n_ap    = 1'b1;
                end
            end
            OP_CONNECTED: begin
                n_retries = '0;
                n_trig    = '0;
                n_creds   = 1'b1;
                if (r_ap) begin
                    n_state  = S_GRACE;
                    n_gstart = i_item.now_ms;
                end else begin
                    n_state = S_STAONLY;
                end
            end
            OP_FAILED: begin
                n_retries = sat_inc(r_retries);
                n_trig    = sat_inc(r_trig);
                if (!r_creds) begin
                    n_state = S_UNPROV;
                    n_ap    = 1'b1;
                end else if (n_trig >= r_thresh) begin
                    n_state = S_ASSIST;
                    n_ap    = 1'b1;
                end else begin
                    n_state = S_CONNECT;
                end
            end
            OP_LOST: begin
                if (r_state != S_ASSIST) begin
                    n_state = S_CONNECT;
                end
                n_gstart = '0;
            end
            OP_SUBMITTED: begin
                n_retries = '0;
                n_trig    = '0;
                n_state   = S_CONNECT;
            end
            OP_CLEARED: begin
                n_creds   = 1'b0;
                n_retries = '0;
                n_trig    = '0;
                n_gstart  = '0;
                n_state   = S_UNPROV;
                n_ap      = 1'b1;
            end
            OP_CLIENT_LEFT: begin
                if (r_state == S_GRACE) begin
                    n_ap     = 1'b0;
                    n_gstart = '0;
                    n_state  = S_STAONLY;
                end
            end
            OP_RAISE: begin
                n_ap = 1'b1;
            end
            OP_TEARDOWN: begin
                n_ap     = 1'b0;
                n_gstart = '0;
                if (r_state == S_GRACE) begin
                    n_state = S_STAONLY;
                end
            end
            default: begin
                // tick and unused codes leave the state alone
                n_ap = r_ap;
            end
        endcase
    end

    // elapsed grace time, zero when the clock runs backwards
    assign w_diff    = {1'b0, i_item.now_ms} - {1'b0, n_gstart};
    assign w_elapsed = w_diff[TIME_W] ? '0 : w_diff[TIME_W-1:0];

    // report built from the updated state
    always_comb begin
        n_out.state_code         = state_code(n_state);
        n_out.ap_up              = n_ap;
        n_out.raise_advised      = !n_ap && (n_state == S_UNPROV || n_state == S_ASSIST);
        n_out.teardown_advised   = n_ap && (n_state == S_GRACE) &&
                                   (w_elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, r_limit});
        n_out.credentials_proven = n_creds;
        n_out.retry_count        = n_retries;
        n_out.trigger_count      = n_trig;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_UNPROV;
            r_creds   <= 1'b0;
            r_retries <= '0;
            r_trig    <= '0;
            r_ap      <= 1'b0;
            r_gstart  <= '0;
        end else if (w_step) begin
            r_state   <= n_state;
            r_creds   <= n_creds;
            r_retries <= n_retries;
            r_trig    <= n_trig;
            r_ap      <= n_ap;
            r_gstart  <= n_gstart;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_advance) begin
            r_out_vld <= i_item_vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // teardown is only ever advised with the access point up in grace
    a_teardown_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.teardown_advised |->
            r_out.ap_up && r_out.state_code == CODE_GRACE)
        else $error("teardown advised outside grace");

    // raise and teardown advice never coincide
    a_advice_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.raise_advised && r_out.teardown_advised))
        else $error("raise and teardown advised together");

    // a waiting result is never dropped
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld)
        else $error("stalled result lost");

    // state stays one-hot
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    // state only moves when an event is applied
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_state) && $stable(r_gstart))
        else $error("state changed without an event");

endmodule

`default_nettype wire
